// ===== rtl/core/sqrt_continued_fraction_macros.svh =====
// ----------------------------------------------------------------------------
// sqrt continued fraction assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SQRT_CONTINUED_FRACTION_MACROS_SVH
`define SQRT_CONTINUED_FRACTION_MACROS_SVH

// same-cycle implication
`define SQCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SQCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sqcf_pkg.sv =====
// ----------------------------------------------------------------------------
// sqcf_pkg
// shared types and constants of the square root continued fraction block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqcf_pkg;

	localparam int DEF_MAX_PERIOD   = 63;
	localparam int DEF_NUMBER_WIDTH = 32;

	localparam int IN_DATA_W  = 32;
	localparam int TERM_W     = 17;
	localparam int IDX_W      = 6;
	localparam int OUT_DATA_W = 32;
	localparam int USER_W     = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_FIRST,
		ST_SQ,
		ST_NUM,
		ST_DIV1,
		ST_DIV2_GO,
		ST_DIV2,
		ST_PROD,
		ST_UPD,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic root_step;
		logic push_first;
		logic init_run;
		logic sq_calc;
		logic div_start;
		logic div_sel;
		logic nd_latch;
		logic t_latch;
		logic prod_calc;
		logic update;
		logic push_term;
	} cmd_t;

	typedef struct packed {
		logic root_last;
		logic is_square;
		logic div_done;
		logic out_free;
		logic closed;
		logic at_max;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqcf_div.sv =====
// ----------------------------------------------------------------------------
// sqcf_div
// restoring divider, one quotient bit per cycle, quotient known to fit QW bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqcf_div #(
	parameter int DW = 32,
	parameter int QW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [QW-1:0] divisor,
	output logic               done,
	output logic [QW-1:0]      quotient
);

	localparam int SHW = 2 * QW - 1;
	localparam int CW  = $clog2(QW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [SHW-1:0] sh_q;
	logic [QW-1:0] q_q;
	logic          ge;

	assign ge = SHW'(rem_q) >= sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// divisor walks down from its top alignment, one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			sh_q  <= SHW'(divisor) << (QW - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - sh_q[DW-1:0];
			end
			q_q  <= {q_q[QW-2:0], ge};
			sh_q <= sh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

`default_nettype wire

// ===== rtl/core/sqcf_datapath.sv =====
// ----------------------------------------------------------------------------
// sqcf_datapath
// integer square root, term recurrence registers and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sqrt_continued_fraction_macros.svh"

module sqcf_datapath
	import sqcf_pkg::*;
#(
	parameter int MAX_PERIOD   = DEF_MAX_PERIOD,
	parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  number_in,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast,
	output logic [USER_W-1:0]          m_tuser
);

	localparam int NW   = NUMBER_WIDTH;
	localparam int RW   = (NW + 1) / 2;
	localparam int QW   = RW + 1;
	localparam int RADW = 2 * RW;
	localparam int RCW  = $clog2(RW);
	localparam int EXW  = TERM_W + QW;
	localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_PERIOD);

	// root extraction
	logic [RCW-1:0]   rcnt_q;
	logic [RADW-1:0]  rad_q;
	logic [RW+1:0]    rem_q;
	logic [RW-1:0]    a0_q;
	logic [RW+1:0]    rem_sh;
	logic [RW+1:0]    trial;
	logic             take;

	// recurrence
	logic [NW-1:0]    n_q;
	logic [RW-1:0]    m_q;
	logic [QW-1:0]    d_q;
	logic [QW-1:0]    nd_q;
	logic [QW-1:0]    t_q;
	logic [RADW-1:0]  mm_q;
	logic [2*QW-1:0]  prod_q;
	logic [IDX_W-1:0] cnt_q;
	logic [RADW-1:0]  num_diff;
	logic [QW-1:0]    am_sum;
	logic [2*QW-1:0]  m_new;
	logic [NW-1:0]    div_dividend;
	logic [QW-1:0]    div_divisor;
	logic             div_done;
	logic [QW-1:0]    div_q;

	// output register
	logic                  valid_q;
	logic [TERM_W-1:0]     term_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  last_q;
	logic [IDX_W-1:0]      plen_q;
	logic                  trunc_q;
	logic                  sq_q;
	logic [EXW-1:0]        a0_ext;
	logic [EXW-1:0]        t_ext;
	logic                  out_free;
	logic                  closed;
	logic                  at_max;
	logic                  term_end;

	// two radicand bits brought down per step
	assign rem_sh = {rem_q[RW-1:0], rad_q[RADW-1 -: 2]};
	assign trial  = {a0_q, 2'b01};
	assign take   = rem_sh >= trial;

	assign num_diff     = RADW'(n_q) - mm_q;
	assign am_sum       = QW'(a0_q) + QW'(m_q);
	assign div_dividend = cmd.div_sel ? NW'(am_sum) : num_diff[NW-1:0];
	assign div_divisor  = cmd.div_sel ? nd_q : d_q;
	assign m_new        = prod_q - (2 * QW)'(m_q);

	sqcf_div #(
		.DW (NW),
		.QW (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign closed   = (d_q == QW'(1)) && (m_q == a0_q);
	assign at_max   = cnt_q == MAX_CNT;
	assign term_end = closed || at_max;
	assign out_free = !valid_q || m_tready;
	assign a0_ext   = {{TERM_W{1'b0}}, 1'b0, a0_q};
	assign t_ext    = {{TERM_W{1'b0}}, t_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rcnt_q  <= '0;
		end else begin
			if (cmd.push_first || cmd.push_term) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			if (cmd.load) begin
				rcnt_q <= RCW'(RW - 1);
			end else if (cmd.root_step && (rcnt_q != '0)) begin
				rcnt_q <= rcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= NW'(number_in);
			rad_q <= RADW'(NW'(number_in));
			rem_q <= '0;
			a0_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RADW-3:0], 2'b00};
			rem_q <= take ? (rem_sh - trial) : rem_sh;
			a0_q  <= {a0_q[RW-2:0], take};
		end
		if (cmd.init_run) begin
			m_q   <= a0_q;
			d_q   <= QW'(1);
			cnt_q <= '0;
		end else if (cmd.update) begin
			m_q   <= m_new[RW-1:0];
			d_q   <= nd_q;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.sq_calc) begin
			mm_q <= m_q * m_q;
		end
		if (cmd.nd_latch) begin
			nd_q <= div_q;
		end
		if (cmd.t_latch) begin
			t_q <= div_q;
		end
		if (cmd.prod_calc) begin
			prod_q <= nd_q * t_q;
		end
		if (cmd.push_first) begin
			term_q  <= a0_ext[TERM_W-1:0];
			idx_q   <= '0;
			last_q  <= sts.is_square;
			plen_q  <= '0;
			trunc_q <= 1'b0;
			sq_q    <= sts.is_square;
		end else if (cmd.push_term) begin
			term_q  <= t_ext[TERM_W-1:0];
			idx_q   <= cnt_q;
			last_q  <= term_end;
			plen_q  <= term_end ? cnt_q : '0;
			trunc_q <= at_max && !closed;
			sq_q    <= 1'b0;
		end
	end

	always_comb begin
		sts           = '0;
		sts.root_last = rcnt_q == '0;
		sts.is_square = rem_q == '0;
		sts.div_done  = div_done;
		sts.out_free  = out_free;
		sts.closed    = closed;
		sts.at_max    = at_max;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_DATA_W'({plen_q, idx_q, term_q});
	assign m_tlast  = last_q;
	assign m_tuser  = {sq_q, trunc_q};

	`SQCF_ASSERT_NOW(a_push_needs_room, cmd.push_first || cmd.push_term, out_free, "result pushed over a waiting result")
	`SQCF_ASSERT_NOW(a_denominator_nonzero, cmd.div_start && !cmd.div_sel, d_q != '0, "division by a zero denominator")
	`SQCF_ASSERT_NEXT(a_max_ends_run, cmd.push_term && at_max, valid_q && last_q, "run went past the period limit")
	`SQCF_ASSERT_NOW(a_square_single, valid_q && sq_q, last_q && (idx_q == '0) && !trunc_q, "square result malformed")

endmodule

`default_nettype wire

// ===== rtl/core/sqcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqcf_ctrl
// sequencer for root extraction and the per-term divide and update steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqcf_ctrl
	import sqcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (sts.root_last) state_d = ST_FIRST;
			end
			ST_FIRST: begin
				if (sts.out_free) state_d = sts.is_square ? ST_IDLE : ST_SQ;
			end
			ST_SQ:      state_d = ST_NUM;
			ST_NUM:     state_d = ST_DIV1;
			ST_DIV1: begin
				if (sts.div_done) state_d = ST_DIV2_GO;
			end
			ST_DIV2_GO: state_d = ST_DIV2;
			ST_DIV2: begin
				if (sts.div_done) state_d = ST_PROD;
			end
			ST_PROD:    state_d = ST_UPD;
			ST_UPD:     state_d = ST_PUSH;
			ST_PUSH: begin
				if (sts.out_free) state_d = (sts.closed || sts.at_max) ? ST_IDLE : ST_SQ;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ROOT:    cmd.root_step = 1'b1;
			ST_FIRST: begin
				cmd.push_first = sts.out_free;
				cmd.init_run   = sts.out_free;
			end
			ST_SQ:      cmd.sq_calc = 1'b1;
			ST_NUM:     cmd.div_start = 1'b1;
			ST_DIV1:    cmd.nd_latch = sts.div_done;
			ST_DIV2_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
			end
			ST_DIV2:    cmd.t_latch = sts.div_done;
			ST_PROD:    cmd.prod_calc = 1'b1;
			ST_UPD:     cmd.update = 1'b1;
			ST_PUSH:    cmd.push_term = sts.out_free;
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/sqrt_continued_fraction.sv =====
// ----------------------------------------------------------------------------
// sqrt_continued_fraction
// continued fraction expansion of the square root of a natural number
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one item, the number n, in s_tdata. s_tready is high
//   only while no expansion runs; a result still waiting on m_* does not hold
//   off the next item.
//   m_* channel gives the integer part a0 first, then one item per periodic
//   term; m_tlast marks the final item of a number's run, which also carries
//   the period length. m_tuser flags a perfect square (single item) or a run
//   cut off at MAX_PERIOD terms.
//   a0 is extracted one bit per step, R = ceil(NUMBER_WIDTH/2) bits (16 by
//   default); each further term runs the shared one-bit-per-cycle divider
//   twice.
//   a stalled receiver holds the output register; the sequencer waits at its
//   next result until the register frees, so nothing is dropped.
//   reset clears the sequencer and the output valid; no item is pending after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqrt_continued_fraction
	import sqcf_pkg::*;
#(
	parameter int MAX_PERIOD   = DEF_MAX_PERIOD,
	parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] number_in
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // [16:0] term, [22:17] term_index,
	                                             // [28:23] period_length, [31:29] zero
	output logic                       m_tlast,
	output logic [USER_W-1:0]          m_tuser   // [0] truncated, [1] square_error
);

	cmd_t cmd;
	sts_t sts;

	sqcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sqcf_datapath #(
		.MAX_PERIOD   (MAX_PERIOD),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.number_in (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for sqrt_continued_fraction
// streams natural numbers into the block, expands each one alongside it into
// the continued fraction of its square root and checks every output item in
// order, under random gaps on the input and random back-pressure on the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import sqcf_pkg::*;

	localparam int RANDOM_NUMBERS = 410;
	localparam int TAIL_ITEMS     = 40;
	localparam int LONG_HOLD      = 600;
	localparam int SETTLE_CYCLES  = 200;
	localparam int IDX_LSB        = TERM_W;
	localparam int PLEN_LSB       = TERM_W + IDX_W;
	localparam int PAD_LSB        = TERM_W + 2 * IDX_W;

	typedef struct {
		bit [TERM_W-1:0] term;
		bit [IDX_W-1:0]  index;
		bit              last;
		bit [IDX_W-1:0]  period;
		bit              cut;
		bit              square;
	} cf_term_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic [USER_W-1:0]     m_tuser;

	bit [IN_DATA_W-1:0] pending_numbers[$];
	cf_term_t           expected_terms[$];
	int                 drain_points[$];
	int                 numbers_offered  = 0;
	int                 numbers_accepted = 0;
	int                 hold_trigger     = -1;
	int                 long_hold_left   = 0;
	bit                 long_hold_done   = 1'b0;
	int                 send_gap         = 0;
	int                 sink_stall       = 0;
	bit                 source_calm      = 1'b0;
	bit                 sink_calm        = 1'b0;
	bit                 tail_phase       = 1'b0;
	int                 mismatch_count   = 0;
	cf_term_t           want_term;

	// predictor's copy of the last expansion
	longint unsigned cf_number, cf_root, cf_offset, cf_denom;
	int              cf_terms;

	sqrt_continued_fraction i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void note_term(bit record, longint unsigned term, int index, bit last,
			int period, bit cut, bit square);
		cf_term_t item;
		if (record) begin
			item.term   = term[TERM_W-1:0];
			item.index  = index[IDX_W-1:0];
			item.last   = last;
			item.period = period[IDX_W-1:0];
			item.cut    = cut;
			item.square = square;
			expected_terms.push_back(item);
		end
	endfunction

	// expands sqrt(number); returns the period length, 0 for a square and
	// DEF_MAX_PERIOD + 1 for a run that is cut off
	function automatic int expand_root(bit [IN_DATA_W-1:0] number, bit record);
		longint unsigned n, a0, probe, m, d, nd, t;
		int  b, cnt, result;
		bit  closed;
		n  = longint'(number) & ((64'd1 << DEF_NUMBER_WIDTH) - 64'd1);
		a0 = 0;
		for (b = 31; b >= 0; b--) begin
			probe = a0 | (64'd1 << b);
			if (probe * probe <= n)
				a0 = probe;
		end
		m      = a0;
		d      = 1;
		cnt    = 0;
		result = -1;
		if (a0 * a0 == n) begin
			note_term(record, a0, 0, 1'b1, 0, 1'b0, 1'b1);
			result = 0;
		end else begin
			note_term(record, a0, 0, 1'b0, 0, 1'b0, 1'b0);
			while (cnt < DEF_MAX_PERIOD && result < 0) begin
				nd = (n - m * m) / d;
				if (nd == 0)
					break;
				t      = (a0 + m) / nd;
				m      = nd * t - m;
				d      = nd;
				cnt++;
				closed = (d == 1 && m == a0);
				if (closed || cnt == DEF_MAX_PERIOD) begin
					note_term(record, t, cnt, 1'b1, cnt, !closed, 1'b0);
					result = closed ? cnt : DEF_MAX_PERIOD + 1;
				end else begin
					note_term(record, t, cnt, 1'b0, 0, 1'b0, 1'b0);
				end
			end
			// a zero divisor closes the run on the item already noted
			if (result < 0) begin
				if (record) begin
					expected_terms[$].last   = 1'b1;
					expected_terms[$].period = cnt[IDX_W-1:0];
					expected_terms[$].cut    = 1'b1;
				end
				result = DEF_MAX_PERIOD + 1;
			end
		end
		if (record) begin
			cf_number = n;
			cf_root   = a0;
			cf_offset = m;
			cf_denom  = d;
			cf_terms  = cnt;
		end
		return result;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_count++;
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid         <= 1'b0;
			s_tdata          <= '0;
			send_gap         <= 0;
			numbers_accepted <= 0;
			tail_phase       <= 1'b0;
			source_calm      <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				void'(expand_root(s_tdata, 1'b1));
				numbers_accepted <= numbers_accepted + 1;
			end
			tail_phase <= (pending_numbers.size() <= TAIL_ITEMS);
			if ($urandom_range(0, 199) == 0)
				source_calm <= !source_calm;
			if (!s_tvalid || s_tready) begin
				if (drain_points.size() != 0 && numbers_offered == drain_points[0]) begin
					// hold back until every outstanding term has come out
					s_tvalid <= 1'b0;
					if (expected_terms.size() == 0)
						void'(drain_points.pop_front());
				end else if (send_gap != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_numbers.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!tail_phase && !source_calm && $urandom_range(0, 5) == 0) begin
					s_tvalid <= 1'b0;
					send_gap <= $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_numbers.pop_front();
					numbers_offered++;
				end
			end
		end
	end

	// one long receiver hold-off so the sequencer backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
		end else if (!long_hold_done && numbers_accepted == hold_trigger) begin
			long_hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			sink_stall <= 0;
			sink_calm  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_terms.size() == 0) begin
					report_mismatch("unexpected item, term", m_tdata[TERM_W-1:0], 0);
				end else begin
					want_term = expected_terms.pop_front();
					if (m_tdata[TERM_W-1:0] !== want_term.term)
						report_mismatch("term", m_tdata[TERM_W-1:0], want_term.term);
					if (m_tdata[IDX_LSB +: IDX_W] !== want_term.index)
						report_mismatch("term_index", m_tdata[IDX_LSB +: IDX_W],
							want_term.index);
					if (m_tdata[PLEN_LSB +: IDX_W] !== want_term.period)
						report_mismatch("period_length", m_tdata[PLEN_LSB +: IDX_W],
							want_term.period);
					if (m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
						report_mismatch("tdata padding", m_tdata[OUT_DATA_W-1:PAD_LSB], 0);
					if (m_tlast !== want_term.last)
						report_mismatch("last_term", m_tlast, want_term.last);
					if (m_tuser[0] !== want_term.cut)
						report_mismatch("truncated", m_tuser[0], want_term.cut);
					if (m_tuser[1] !== want_term.square)
						report_mismatch("square_error", m_tuser[1], want_term.square);
				end
			end
			if ($urandom_range(0, 199) == 0)
				sink_calm <= !sink_calm;
			if (long_hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (sink_stall != 0) begin
				m_tready   <= 1'b0;
				sink_stall <= sink_stall - 1;
			end else if (!tail_phase && !sink_calm && $urandom_range(0, 7) == 0) begin
				m_tready   <= 1'b0;
				sink_stall <= $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		longint unsigned probe, root;
		longint          near;
		int              plen, pick, i, directed_count;
		bit [31:0]       exact_period_n, first_cut_n;
		bit              found_exact, found_cut;

		found_exact    = 1'b0;
		found_cut      = 1'b0;
		exact_period_n = 32'd2;
		first_cut_n    = 32'd2;
		// look for a period of exactly the limit and the first run that is cut off
		for (probe = 2; probe < 200000 && !(found_exact && found_cut); probe++) begin
			plen = expand_root(probe[31:0], 1'b0);
			if (plen == DEF_MAX_PERIOD && !found_exact) begin
				exact_period_n = probe[31:0];
				found_exact    = 1'b1;
			end
			if (plen > DEF_MAX_PERIOD && !found_cut) begin
				first_cut_n = probe[31:0];
				found_cut   = 1'b1;
			end
		end

		// directed: zero and one, short periods, extremes, squares at both ends
		pending_numbers.push_back(32'd0);
		pending_numbers.push_back(32'd1);
		pending_numbers.push_back(32'd2);
		pending_numbers.push_back(32'd3);
		pending_numbers.push_back(32'd7);
		pending_numbers.push_back(32'd13);
		pending_numbers.push_back(32'd46);
		pending_numbers.push_back(32'd94);
		pending_numbers.push_back(32'd16777216);
		pending_numbers.push_back(32'd4294836225);
		pending_numbers.push_back(32'd4294836226);
		pending_numbers.push_back(32'd4294836227);
		pending_numbers.push_back(32'hFFFF_FFFE);
		pending_numbers.push_back(32'hFFFF_FFFF);
		pending_numbers.push_back(32'h8000_0000);
		pending_numbers.push_back(32'hAAAA_AAAA);
		pending_numbers.push_back(32'h5555_5555);
		pending_numbers.push_back(32'd1000);
		pending_numbers.push_back(exact_period_n);
		pending_numbers.push_back(first_cut_n);
		pending_numbers.push_back(32'd3_000_000_019);
		directed_count = pending_numbers.size();

		// random: small numbers, near squares, squares and full-width values
		for (i = 0; i < RANDOM_NUMBERS; i++) begin
			pick = $urandom_range(0, 99);
			root = $urandom_range(1, 65535);
			if (pick < 30) begin
				pending_numbers.push_back($urandom_range(2, 5000));
			end else if (pick < 55) begin
				near = longint'(root * root) + longint'($urandom_range(0, 6)) - 3;
				if (near < 1 || near > 64'hFFFF_FFFF)
					near = longint'(root * root);
				pending_numbers.push_back(near[31:0]);
			end else if (pick < 65) begin
				probe = root * root;
				pending_numbers.push_back(probe[31:0]);
			end else begin
				pending_numbers.push_back($urandom);
			end
		end

		drain_points.push_back(directed_count);
		drain_points.push_back(directed_count + 200);
		hold_trigger = directed_count + 80;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_numbers.size() == 0 && !s_tvalid);
		wait (expected_terms.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sqrt_continued_fraction.f =====
+incdir+rtl/core
rtl/core/sqcf_pkg.sv
rtl/core/sqcf_div.sv
rtl/core/sqcf_datapath.sv
rtl/core/sqcf_ctrl.sv
rtl/core/sqrt_continued_fraction.sv
tb/testbench.sv
